// File: rtl/core/lbcd_pkg.sv
// ----------------------------------------------------------------------------
// lbcd_pkg
// shared types and constants of the lru block cache directory
// ----------------------------------------------------------------------------
package lbcd_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;

  localparam int HANDLE_W = 32;
  localparam int OFFSET_W = 63;
  localparam int LEN_W    = 20;
  localparam int BSIZE_W  = 14;
  localparam int NUSE_W   = 7;
  localparam int SLOT_W   = 6;
  localparam int STAMP_W  = 32;
  localparam int CTR_W    = 32;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [BSIZE_W-1:0] BSIZE_RST = BSIZE_W'(16'h0200);
  localparam logic [NUSE_W-1:0]  NUSE_RST  = NUSE_W'(64);

  typedef enum logic [1:0] {
    REG_DEVICE = 2'd0,
    REG_BSIZE  = 2'd1,
    REG_NUSE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] device_handle;
    logic [OFFSET_W-1:0] byte_offset;
    logic [LEN_W-1:0]    request_length;
    logic                use_cache;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              read_disk;
    logic              fill;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [LEN_W-1:0]  returned_length;
    logic [CTR_W-1:0]  hit_total;
    logic [CTR_W-1:0]  miss_total;
    logic [CTR_W-1:0]  evict_total;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [OFFSET_W-1:0] offset;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/core/lbcd_req_if.sv
// ----------------------------------------------------------------------------
// lbcd_req_if
// request channel: valid, ready and one request word
// ----------------------------------------------------------------------------
interface lbcd_req_if;
  logic            valid;
  logic            ready;
  lbcd_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/lbcd_rsp_if.sv
// ----------------------------------------------------------------------------
// lbcd_rsp_if
// result channel: valid, ready and one result word
// ----------------------------------------------------------------------------
interface lbcd_rsp_if;
  logic            valid;
  logic            ready;
  lbcd_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/lbcd_ram.sv
// ----------------------------------------------------------------------------
// lbcd_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/lru_block_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_block_cache_directory
// tag directory of a fully associative block cache with timestamp lru
// ----------------------------------------------------------------------------
// A request that is not cacheable (flag clear, wrong device, zero handle or
// length other than the block size) goes from idle straight to the update
// state once accepted. A cacheable request scans the tag memory one entry
// per cycle through its single read port, looking for a match, the first
// free slot and the oldest stamp at once among the active slots; a hit ends
// the scan at the matching slot. The result sits in an output register, so
// the next request is taken while the previous result waits. Writing the
// device register clears the table, the use clock and the counters.
module lru_block_cache_directory (
  input  logic                                clk,
  input  logic                                rst_n,
  lbcd_req_if.sink                            in_req,
  lbcd_rsp_if.source                          out_rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lbcd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lbcd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lbcd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int IDX_W = lbcd_pkg::IDX_W;
  localparam int CNT_W = lbcd_pkg::CNT_W;

  lbcd_pkg::state_t state_r, state_nxt;

  logic [lbcd_pkg::HANDLE_W-1:0] cached_dev_r;
  logic [lbcd_pkg::BSIZE_W-1:0]  bsize_r;
  logic [lbcd_pkg::NUSE_W-1:0]   nuse_r;

  lbcd_pkg::req_t req_r;
  logic           cacheable_r;

  logic [CNT_W-1:0] scan_idx_r;
  logic             rdv_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_found_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [lbcd_pkg::STAMP_W-1:0] best_time_r;
  logic [IDX_W-1:0] best_idx_r;

  logic [lbcd_pkg::MAX_ENTRIES-1:0] valid_r;
  logic [lbcd_pkg::STAMP_W-1:0]     use_clock_r;
  logic [lbcd_pkg::CTR_W-1:0]       hits_r, misses_r, evicts_r;

  logic           out_valid_r;
  lbcd_pkg::rsp_t out_data_r;

  logic [CNT_W-1:0]     n_act;
  logic                 cfg_wr, dev_wr;
  logic                 cacheable_in, in_fire;
  logic                 in_ready_c, scan_act, upd_act;
  logic                 out_free, upd_fire;
  logic                 issue;
  lbcd_pkg::entry_t     ram_rdata, ent;
  logic                 ent_valid, ent_match, scan_last, scan_done;
  logic                 hit_c, fill_c, evict_c;
  logic [IDX_W-1:0]     slot_sel;
  logic [lbcd_pkg::STAMP_W-1:0] clock_inc;
  logic [lbcd_pkg::CTR_W-1:0]   hits_nxt, misses_nxt, evicts_nxt;
  logic                 ram_we;
  lbcd_pkg::entry_t     ram_wdata;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign dev_wr = cfg_wr && (lbcd_pkg::reg_idx_t'(paddr[3:2]) == lbcd_pkg::REG_DEVICE);

  always_comb begin
    prdata = '0;
    case (lbcd_pkg::reg_idx_t'(paddr[3:2]))
      lbcd_pkg::REG_DEVICE: prdata = cached_dev_r;
      lbcd_pkg::REG_BSIZE:  prdata = lbcd_pkg::APB_DATA_W'(bsize_r);
      lbcd_pkg::REG_NUSE:   prdata = lbcd_pkg::APB_DATA_W'(nuse_r);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cached_dev_r <= '0;
      bsize_r      <= lbcd_pkg::BSIZE_RST;
      nuse_r       <= lbcd_pkg::NUSE_RST;
    end else if (cfg_wr) begin
      case (lbcd_pkg::reg_idx_t'(paddr[3:2]))
        lbcd_pkg::REG_DEVICE: cached_dev_r <= pwdata;
        lbcd_pkg::REG_BSIZE:  bsize_r      <= pwdata[lbcd_pkg::BSIZE_W-1:0];
        lbcd_pkg::REG_NUSE:   nuse_r       <= pwdata[lbcd_pkg::NUSE_W-1:0];
        default: ;
      endcase
    end
  end

  // active slot count, zero taken as one, saturated at the table size
  always_comb begin
    if (nuse_r == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(nuse_r) > lbcd_pkg::MAX_ENTRIES) begin
      n_act = CNT_W'(lbcd_pkg::MAX_ENTRIES);
    end else begin
      n_act = CNT_W'(nuse_r);
    end
  end

  assign cacheable_in = in_req.data.use_cache
                     && (in_req.data.device_handle != '0)
                     && (in_req.data.device_handle == cached_dev_r)
                     && (in_req.data.request_length == lbcd_pkg::LEN_W'(bsize_r));

  // tag memory
  lbcd_ram #(
    .WIDTH (lbcd_pkg::ENTRY_W),
    .DEPTH (lbcd_pkg::MAX_ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_sel),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // scan compare, entries never written read as free
  assign ent_valid = valid_r[cmp_idx_r];
  assign ent       = ent_valid ? ram_rdata : '0;
  assign ent_match = ent_valid
                  && (ent.handle == req_r.device_handle)
                  && (ent.offset == req_r.byte_offset);
  assign scan_last = (cmp_idx_r == IDX_W'(n_act - CNT_W'(1)));
  assign scan_done = rdv_r && (ent_match || scan_last);
  assign issue     = scan_act && (scan_idx_r < n_act);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbcd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = cacheable_in ? lbcd_pkg::ST_SCAN : lbcd_pkg::ST_UPDATE;
        end
      end
      lbcd_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = lbcd_pkg::ST_UPDATE;
        end
      end
      lbcd_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_nxt = lbcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lbcd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_c = 1'b0;
    scan_act   = 1'b0;
    upd_act    = 1'b0;
    case (state_r)
      lbcd_pkg::ST_IDLE:   in_ready_c = 1'b1;
      lbcd_pkg::ST_SCAN:   scan_act   = 1'b1;
      lbcd_pkg::ST_UPDATE: upd_act    = 1'b1;
      default: ;
    endcase
  end

  assign in_req.ready = in_ready_c;
  assign in_fire      = in_req.valid && in_ready_c;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign upd_fire     = upd_act && out_free;

  // update decisions
  assign hit_c     = hit_found_r;
  assign fill_c    = cacheable_r && !hit_found_r;
  assign evict_c   = fill_c && !free_found_r;
  assign clock_inc = use_clock_r + lbcd_pkg::STAMP_W'(1);

  always_comb begin
    if (hit_c) begin
      slot_sel = hit_idx_r;
    end else if (fill_c) begin
      slot_sel = free_found_r ? free_idx_r : best_idx_r;
    end else begin
      slot_sel = '0;
    end
  end

  assign hits_nxt   = hits_r + lbcd_pkg::CTR_W'(hit_c);
  assign misses_nxt = misses_r + lbcd_pkg::CTR_W'(!hit_c && req_r.use_cache);
  assign evicts_nxt = evicts_r + lbcd_pkg::CTR_W'(evict_c);

  assign ram_we    = upd_fire && cacheable_r;
  assign ram_wdata = '{handle: req_r.device_handle, offset: req_r.byte_offset,
                       stamp: clock_inc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else if (in_fire) begin
      rdv_r <= 1'b0;
    end else if (scan_act) begin
      rdv_r <= issue && !scan_done;
    end else begin
      rdv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r        <= in_req.data;
      cacheable_r  <= cacheable_in;
      scan_idx_r   <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      best_time_r  <= use_clock_r;
      best_idx_r   <= '0;
    end else if (scan_act) begin
      if (issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      cmp_idx_r <= scan_idx_r[IDX_W-1:0];
      if (rdv_r) begin
        if (ent_match) begin
          hit_found_r <= 1'b1;
          hit_idx_r   <= cmp_idx_r;
        end
        if (!ent_valid && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= cmp_idx_r;
        end
        if (ent.stamp < best_time_r) begin
          best_time_r <= ent.stamp;
          best_idx_r  <= cmp_idx_r;
        end
      end
    end
  end

  // directory state, a device write clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      use_clock_r <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
    end else if (dev_wr) begin
      valid_r     <= '0;
      use_clock_r <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
    end else if (upd_fire) begin
      if (cacheable_r) begin
        valid_r[slot_sel] <= 1'b1;
        use_clock_r       <= clock_inc;
      end
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_data_r.hit             <= hit_c;
      out_data_r.read_disk       <= !hit_c;
      out_data_r.fill            <= fill_c;
      out_data_r.slot            <= lbcd_pkg::SLOT_W'(slot_sel);
      out_data_r.evicted         <= evict_c;
      out_data_r.returned_length <= hit_c ? lbcd_pkg::LEN_W'(bsize_r)
                                          : req_r.request_length;
      out_data_r.hit_total       <= hits_nxt;
      out_data_r.miss_total      <= misses_nxt;
      out_data_r.evict_total     <= evicts_nxt;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

`ifndef SYNTHESIS
  a_fill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && !dev_wr |=> valid_r[$past(slot_sel)])
    else $error("written slot not marked valid");

  a_clock_advances: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire && cacheable_r && !dev_wr |=> use_clock_r == $past(clock_inc))
    else $error("use clock did not advance on a cacheable request");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_act && rdv_r |-> CNT_W'(cmp_idx_r) < n_act)
    else $error("scan compared an entry beyond the active count");
`endif

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench of the lru block cache directory
// ----------------------------------------------------------------------------
// A short table of requests and register writes runs first: field extremes,
// zero handle, wrong length, flag clear, hit, fill, eviction, slot counts of
// zero and above the table size, block size change without clearing. Random
// phases follow under several register settings, mostly well-formed reads
// from a small offset pool so that hits and evictions are frequent, mixed
// with noise. Every result word is checked field by field against a model
// of the directory in the testbench or a table word. The sender idles in
// bursts, the receiver stalls on a fixed pattern with occasional long holds.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REG_UNUSED = 3;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_WORDS = 105;
  localparam logic [30:0] STALL_PATTERN = 31'h2D3C_8E59;

  typedef struct {
    bit             is_cfg;
    int unsigned    reg_i;
    logic [31:0]    reg_v;
    lbcd_pkg::req_t r;
    bit             typed;
    lbcd_pkg::rsp_t e;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lbcd_pkg::APB_ADDR_W-1:0] paddr;
  logic [lbcd_pkg::APB_DATA_W-1:0] pwdata;
  logic [lbcd_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  lbcd_req_if req_ch ();
  lbcd_rsp_if rsp_ch ();

  lru_block_cache_directory uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // directory model
  logic [lbcd_pkg::HANDLE_W-1:0] dir_handle [lbcd_pkg::MAX_ENTRIES];
  logic [lbcd_pkg::OFFSET_W-1:0] dir_offset [lbcd_pkg::MAX_ENTRIES];
  logic [lbcd_pkg::STAMP_W-1:0]  dir_stamp  [lbcd_pkg::MAX_ENTRIES];
  logic [lbcd_pkg::STAMP_W-1:0]  lru_clock;
  logic [lbcd_pkg::CTR_W-1:0]    hit_count;
  logic [lbcd_pkg::CTR_W-1:0]    miss_count;
  logic [lbcd_pkg::CTR_W-1:0]    evict_count;
  logic [31:0]                   cache_dev;
  logic [lbcd_pkg::BSIZE_W-1:0]  blk_size;
  logic [lbcd_pkg::NUSE_W-1:0]   slot_limit;

  lbcd_pkg::rsp_t                pending_rsp [$];
  dir_row_t                      script [$];
  logic [lbcd_pkg::OFFSET_W-1:0] offset_pool [$];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned hits_got;
  int unsigned fills_got;
  int unsigned evicts_got;
  int unsigned reg_writes;
  int unsigned burst_left;
  bit          tx_idle;
  bit          rx_free;
  int unsigned rx_tick;
  int unsigned hold_left;

  function automatic void wipe_directory();
    for (int i = 0; i < lbcd_pkg::MAX_ENTRIES; i++) begin
      dir_handle[i] = '0;
      dir_offset[i] = '0;
      dir_stamp[i]  = '0;
    end
    lru_clock   = '0;
    hit_count   = '0;
    miss_count  = '0;
    evict_count = '0;
  endfunction

  function automatic lbcd_pkg::rsp_t lookup_block(lbcd_pkg::req_t r);
    lbcd_pkg::rsp_t o;
    int unsigned n;
    int unsigned i;
    int unsigned best_slot;
    logic [lbcd_pkg::STAMP_W-1:0] best_time;
    bit cacheable;
    bit free_found;
    o = '0;
    n = (slot_limit == 0) ? 1 :
        ((slot_limit > lbcd_pkg::MAX_ENTRIES) ? lbcd_pkg::MAX_ENTRIES : slot_limit);
    cacheable = r.use_cache && r.device_handle != 0 && r.device_handle == cache_dev &&
                r.request_length == lbcd_pkg::LEN_W'(blk_size);
    if (cacheable) begin
      for (i = 0; i < n && !o.hit; i++) begin
        if (dir_handle[i] == r.device_handle && dir_offset[i] == r.byte_offset) begin
          lru_clock++;
          dir_stamp[i] = lru_clock;
          hit_count++;
          o.hit  = 1'b1;
          o.slot = lbcd_pkg::SLOT_W'(i);
        end
      end
    end
    if (!o.hit) begin
      if (r.use_cache)
        miss_count++;
      if (cacheable) begin
        best_time  = lru_clock;
        best_slot  = 0;
        free_found = 1'b0;
        for (i = 0; i < n && !free_found; i++) begin
          if (dir_handle[i] == 0) begin
            free_found = 1'b1;
            o.slot = lbcd_pkg::SLOT_W'(i);
          end else if (dir_stamp[i] < best_time) begin
            best_time = dir_stamp[i];
            best_slot = i;
          end
        end
        if (!free_found) begin
          o.slot    = lbcd_pkg::SLOT_W'(best_slot);
          o.evicted = 1'b1;
          evict_count++;
        end
        dir_handle[o.slot] = r.device_handle;
        lru_clock++;
        dir_stamp[o.slot]  = lru_clock;
        dir_offset[o.slot] = r.byte_offset;
        o.fill = 1'b1;
      end
    end
    o.read_disk       = !o.hit;
    o.returned_length = o.hit ? lbcd_pkg::LEN_W'(blk_size) : r.request_length;
    o.hit_total       = hit_count;
    o.miss_total      = miss_count;
    o.evict_total     = evict_count;
    return o;
  endfunction

  function automatic lbcd_pkg::rsp_t disk_only(logic [lbcd_pkg::LEN_W-1:0] len,
                                               logic [lbcd_pkg::CTR_W-1:0] misses);
    lbcd_pkg::rsp_t o;
    o = '0;
    o.read_disk       = 1'b1;
    o.returned_length = len;
    o.miss_total      = misses;
    return o;
  endfunction

  function automatic void add_cfg(int unsigned idx, logic [31:0] v);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_i  = idx;
    row.reg_v  = v;
    script.push_back(row);
  endfunction

  function automatic void add_req(logic [lbcd_pkg::HANDLE_W-1:0] h,
                                  logic [lbcd_pkg::OFFSET_W-1:0] off,
                                  logic [lbcd_pkg::LEN_W-1:0] len, logic flag,
                                  bit typed = 1'b0, lbcd_pkg::rsp_t e = '0);
    dir_row_t row;
    row = '{default: '0};
    row.r.device_handle  = h;
    row.r.byte_offset    = off;
    row.r.request_length = len;
    row.r.use_cache      = flag;
    row.typed = typed;
    row.e     = e;
    script.push_back(row);
  endfunction

  function automatic logic [31:0] nonzero_word();
    logic [31:0] v;
    v = $urandom;
    while (v == 0)
      v = $urandom;
    return v;
  endfunction

  function automatic logic [lbcd_pkg::OFFSET_W-1:0] random_offset();
    return lbcd_pkg::OFFSET_W'({$urandom, $urandom});
  endfunction

  function automatic lbcd_pkg::req_t next_req();
    lbcd_pkg::req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.device_handle  = cache_dev;
    r.byte_offset    = offset_pool[$urandom_range(0, offset_pool.size() - 1)];
    r.request_length = lbcd_pkg::LEN_W'(blk_size);
    r.use_cache      = 1'b1;
    if (pick >= 96) begin
      r.device_handle = '0;
    end else if (pick >= 92) begin
      r.request_length = r.request_length ^
                         (lbcd_pkg::LEN_W'(1) << $urandom_range(0, lbcd_pkg::LEN_W - 1));
    end else if (pick >= 88) begin
      r.use_cache = 1'b0;
    end else if (pick >= 84) begin
      r.device_handle = r.device_handle ^
                        (lbcd_pkg::HANDLE_W'(1) << $urandom_range(0, lbcd_pkg::HANDLE_W - 1));
    end else if (pick >= 76) begin
      r.device_handle  = $urandom;
      r.byte_offset    = random_offset();
      r.request_length = lbcd_pkg::LEN_W'($urandom_range(0, 20'hFFFFF));
      r.use_cache      = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_word(lbcd_pkg::rsp_t got);
    lbcd_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      $display("%0t: result word with none expected, actual %p", $time, got);
      errors++;
      return;
    end
    want = pending_rsp.pop_front();
    cmp_field("hit", want.hit, got.hit);
    cmp_field("read_disk", want.read_disk, got.read_disk);
    cmp_field("fill", want.fill, got.fill);
    cmp_field("slot", want.slot, got.slot);
    cmp_field("evicted", want.evicted, got.evicted);
    cmp_field("returned_length", want.returned_length, got.returned_length);
    cmp_field("hit_total", want.hit_total, got.hit_total);
    cmp_field("miss_total", want.miss_total, got.miss_total);
    cmp_field("evict_total", want.evict_total, got.evict_total);
    hits_got   += got.hit;
    fills_got  += got.fill;
    evicts_got += got.evicted;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic push_word(lbcd_pkg::req_t r, bit typed = 1'b0, lbcd_pkg::rsp_t e = '0);
    int unsigned gap;
    lbcd_pkg::rsp_t predicted;
    gap = 0;
    if (tx_idle) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 6);
      end
      burst_left--;
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    predicted = lookup_block(r);
    pending_rsp.push_back(typed ? e : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_access(int unsigned idx, logic [31:0] v);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lbcd_pkg::APB_ADDR_W'(idx * 4);
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    case (idx)
      lbcd_pkg::REG_DEVICE: begin
        cache_dev = v;
        wipe_directory();
      end
      lbcd_pkg::REG_BSIZE: blk_size   = v[lbcd_pkg::BSIZE_W-1:0];
      lbcd_pkg::REG_NUSE:  slot_limit = v[lbcd_pkg::NUSE_W-1:0];
      default: ;
    endcase
    reg_writes++;
    if (idx == REG_UNUSED) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end else begin
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      case (idx)
        lbcd_pkg::REG_DEVICE: want = cache_dev;
        lbcd_pkg::REG_BSIZE:  want = 32'(blk_size);
        default:              want = 32'(slot_limit);
      endcase
      if (prdata !== want) begin
        $display("%0t: register %0d readback mismatch, expected %0h actual %0h",
                 $time, idx, want, prdata);
        errors++;
      end
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d words outstanding", pending_rsp.size());
    $display("RESULT: ERROR");
    $finish;
  end

  always @(negedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (rx_free) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 249) == 0)
        hold_left = $urandom_range(20, 90);
      rsp_ch.ready <= !STALL_PATTERN[rx_tick % 31];
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      check_word(rsp_ch.data);
  end

  initial begin
    logic [lbcd_pkg::HANDLE_W-1:0] dev_a;
    logic [lbcd_pkg::OFFSET_W-1:0] off1, off2, off3, off4, all_ones;
    lbcd_pkg::rsp_t e;
    int unsigned pool_n;
    int unsigned w;

    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    errors       = 0;
    words_sent   = 0;
    hits_got     = 0;
    fills_got    = 0;
    evicts_got   = 0;
    reg_writes   = 0;
    burst_left   = 0;
    rx_tick      = 0;
    hold_left    = 0;
    tx_idle      = 1'b1;
    rx_free      = 1'b0;
    cache_dev    = '0;
    blk_size     = lbcd_pkg::BSIZE_RST;
    slot_limit   = lbcd_pkg::NUSE_RST;
    wipe_directory();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    dev_a    = 32'h8000_0001;
    off1     = 63'h0123_4567_89AB_CDEF;
    off2     = 63'h7FFF_FFFF_FFFF_FFFE;
    off3     = 63'h1;
    off4     = 63'h4000_0000_0000_0000;
    all_ones = '1;

    add_req('0, '0, '0, 1'b0, 1'b1, disk_only(20'h0, 32'd0));
    add_req('1, all_ones, 20'hFFFFF, 1'b1, 1'b1, disk_only(20'hFFFFF, 32'd1));
    add_req('0, '0, 20'd512, 1'b1, 1'b1, disk_only(20'd512, 32'd2));
    add_cfg(lbcd_pkg::REG_DEVICE, dev_a);
    add_cfg(lbcd_pkg::REG_NUSE, 32'd2);
    e = disk_only(20'd512, 32'd1);
    e.fill = 1'b1;
    add_req(dev_a, off1, 20'd512, 1'b1, 1'b1, e);
    add_req(dev_a, off2, 20'd512, 1'b1);
    add_req(dev_a, off1, 20'd512, 1'b1);
    add_req(dev_a, off3, 20'd512, 1'b1);
    add_req(dev_a, off1, 20'd512, 1'b0);
    add_req(dev_a, off1, 20'd513, 1'b1);
    add_req(dev_a ^ 32'h1, off1, 20'd512, 1'b1);
    add_req('0, off1, 20'd512, 1'b1);
    add_cfg(lbcd_pkg::REG_BSIZE, 32'hFFFF_FFFF);
    add_req(dev_a, off1, 20'h3FFF, 1'b1);
    add_cfg(lbcd_pkg::REG_NUSE, 32'd0);
    add_req(dev_a, off3, 20'h3FFF, 1'b1);
    add_req(dev_a, off1, 20'h3FFF, 1'b1);
    add_cfg(lbcd_pkg::REG_NUSE, 32'hFFFF_FFFF);
    add_req(dev_a, off3, 20'h3FFF, 1'b1);
    add_req(dev_a, off4, 20'h3FFF, 1'b1);
    add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    add_req(dev_a, off4, 20'h3FFF, 1'b1);
    add_cfg(lbcd_pkg::REG_DEVICE, 32'h0);
    add_req('0, '0, 20'h3FFF, 1'b1, 1'b1, disk_only(20'h3FFF, 32'd1));

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        settle();
        reg_access(script[k].reg_i, script[k].reg_v);
      end else begin
        push_word(script[k].r, script[k].typed, script[k].e);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      tx_idle = (ph != 2);
      rx_free = (ph == 2 || ph == 5);
      case (ph)
        0: begin
          reg_access(lbcd_pkg::REG_DEVICE, nonzero_word());
          reg_access(lbcd_pkg::REG_BSIZE, 32'd512);
          reg_access(lbcd_pkg::REG_NUSE, 32'd4);
          pool_n = 8;
        end
        1: begin
          reg_access(lbcd_pkg::REG_NUSE, 32'd64);
          pool_n = 96;
        end
        2: begin
          reg_access(lbcd_pkg::REG_NUSE, 32'd8);
          pool_n = 96;
        end
        3: begin
          reg_access(lbcd_pkg::REG_DEVICE, nonzero_word());
          reg_access(lbcd_pkg::REG_BSIZE, $urandom_range(0, 16383));
          reg_access(lbcd_pkg::REG_NUSE, 32'd64);
          pool_n = 40;
        end
        4: begin
          reg_access(lbcd_pkg::REG_DEVICE, 32'hFFFF_FFFF);
          reg_access(lbcd_pkg::REG_BSIZE, 32'd16383);
          reg_access(lbcd_pkg::REG_NUSE, 32'd0);
          pool_n = 5;
        end
        5: begin
          reg_access(lbcd_pkg::REG_NUSE, 32'd127);
          reg_access(lbcd_pkg::REG_BSIZE, 32'd0);
          pool_n = 70;
        end
        6: begin
          reg_access(lbcd_pkg::REG_DEVICE, 32'd0);
          pool_n = 10;
        end
        default: begin
          reg_access(lbcd_pkg::REG_DEVICE, 32'd1);
          reg_access(lbcd_pkg::REG_BSIZE, $urandom_range(512, 16383));
          reg_access(lbcd_pkg::REG_NUSE, $urandom_range(2, 63));
          pool_n = $urandom_range(8, 80);
        end
      endcase
      if (ph != 1 && ph != 2)
        offset_pool.delete();
      while (offset_pool.size() < pool_n)
        offset_pool.push_back(random_offset());
      repeat (PHASE_WORDS)
        push_word(next_req());
    end

    req_ch.valid <= 1'b0;
    for (w = 0; w < 20000 && pending_rsp.size() != 0; w++)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_rsp.size());
      errors += pending_rsp.size();
    end

    $display("covered %0d requests: %0d hits, %0d fills, %0d evictions",
             words_sent, hits_got, fills_got, evicts_got);
    $display("%0d register writes over a directed table and %0d random phases",
             reg_writes, PHASES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
